/* rtl/core/sbmq_pkg.sv */
// Shared definitions for the shared-buffer multi-queue core.
// Sizes, pointer widths, status codes and the link table's reset pattern.
// No dependencies.
`default_nettype none

package sbmq_pkg;

    localparam int SLOTS      = 32;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W = $clog2(SLOTS);
    // one code past the last slot marks a null pointer
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QID_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOTS);

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        FN_ENQ = 1'b0,
        FN_DEQ = 1'b1
    } func_t;

    // link table after reset: slot i points to slot i+1, last slot is null
    function automatic logic [PTR_W-1:0] link_reset_value(input logic [SLOT_W-1:0] slot);
        logic [PTR_W-1:0] p;
        p = PTR_W'(slot);
        return (p == PTR_W'(SLOTS - 1)) ? NIL_PTR : p + PTR_W'(1);
    endfunction

    // item latched at accept, worked off in the execute cycle
    typedef struct packed {
        func_t              func;
        logic [QID_W-1:0]   qid;
        logic [DATA_WIDTH-1:0] value;
        logic [SLOT_W-1:0]  slot;
        logic               ok;
        logic               q_empty;
    } op_t;

endpackage

`default_nettype wire

/* rtl/core/sbmq_link_mem.sv */
// Next-pointer table for queue chains and the free list.
// Synchronous memory, one write and one read port, registered read data.
// Per-entry written bits make unwritten entries read as the reset chain. Uses sbmq_pkg.
`default_nettype none

module sbmq_link_mem (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [sbmq_pkg::SLOT_W-1:0] wr_addr,
    input  wire logic [sbmq_pkg::PTR_W-1:0]  wr_data,
    input  wire logic                       rd_en,
    input  wire logic [sbmq_pkg::SLOT_W-1:0] rd_addr,
    output logic      [sbmq_pkg::PTR_W-1:0]  rd_data
);

    logic [sbmq_pkg::PTR_W-1:0] mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::SLOTS-1:0] written_reg;
    logic [sbmq_pkg::PTR_W-1:0] rd_data_reg;
    logic [sbmq_pkg::PTR_W-1:0] mem_rd_reg;
    logic                       rd_hit_reg;
    logic [sbmq_pkg::PTR_W-1:0] rst_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rd_reg  <= mem[rd_addr];
            rd_hit_reg  <= written_reg[rd_addr];
            rst_val_reg <= sbmq_pkg::link_reset_value(rd_addr);
        end
    end

    always_comb
    begin
        rd_data_reg = rd_hit_reg ? mem_rd_reg : rst_val_reg;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/sbmq_data_mem.sv */
// Slot data store shared by all queues.
// Synchronous memory, one write and one read port, registered read data.
// Contents undefined until written. Uses sbmq_pkg.
`default_nettype none

module sbmq_data_mem (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [sbmq_pkg::SLOT_W-1:0]     wr_addr,
    input  wire logic [sbmq_pkg::DATA_WIDTH-1:0] wr_data,
    input  wire logic                           rd_en,
    input  wire logic [sbmq_pkg::SLOT_W-1:0]     rd_addr,
    output logic      [sbmq_pkg::DATA_WIDTH-1:0] rd_data
);

    logic [sbmq_pkg::DATA_WIDTH-1:0] mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/shared_buffer_multi_queue_core.sv */
// Shared-buffer multi-queue core: control, queue head/tail and free-list registers.
// Depends on sbmq_pkg, sbmq_link_mem and sbmq_data_mem.
//
// Usage:
//   Input channel s_*: one item is an enqueue (s_tuser = 0) or dequeue
//   (s_tuser = 1) on queue queue_id; value_in is the value to enqueue.
//   Output channel m_*: one result per item, status in m_tuser
//   (ok, overflow, underflow), dequeued value in m_tdata (zero otherwise).
//   The accept cycle reads the link and data memories at the slot in play;
//   the execute cycle uses the registered read data, writes the link and
//   data memories back and loads the result into the output register.
//   No new item is taken until the current item's execute cycle has fired.
//   Only one item is in flight, so reads never meet a pending write.
//   The output register holds a result while m_tready is low; a new item
//   is still taken, and its execute cycle waits until the register drains.
//   Reset: all queues empty, free list runs slot 0..SLOTS-1, output empty.
//   No clearing pass; the link table reset pattern comes from valid bits.
`default_nettype none

module shared_buffer_multi_queue_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // [1:0] queue_id, [33:2] value_in, [39:34] zero
    input  wire logic        s_tuser,  // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,  // [31:0] value_out
    output logic      [1:0]  m_tuser   // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    sbmq_pkg::op_t op_reg, op_next;

    logic [sbmq_pkg::PTR_W-1:0]  head_reg [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0]  head_next [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::SLOT_W-1:0] tail_reg [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0]  free_head_reg, free_head_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [31:0]                 m_tdata_reg, m_tdata_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;

    logic                        accept;
    logic                        fire;
    sbmq_pkg::func_t             in_func;
    logic [sbmq_pkg::QID_W-1:0]  in_qid;
    logic                        in_q_ok;
    logic [sbmq_pkg::PTR_W-1:0]  in_head;
    logic [sbmq_pkg::PTR_W-1:0]  in_ptr;

    logic                        link_wr_en;
    logic [sbmq_pkg::SLOT_W-1:0] link_wr_addr;
    logic [sbmq_pkg::PTR_W-1:0]  link_wr_data;
    logic [sbmq_pkg::PTR_W-1:0]  link_rd;
    logic                        data_wr_en;
    logic [sbmq_pkg::DATA_WIDTH-1:0] data_rd;
    logic                        tail_wr_en;
    logic [sbmq_pkg::SLOT_W-1:0] q_tail;
    logic [sbmq_pkg::PTR_W-1:0]  next_ptr;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    assign in_func  = sbmq_pkg::func_t'(s_tuser);
    assign in_qid   = s_tdata[1:0];
    assign in_q_ok  = (32'(in_qid) < sbmq_pkg::QUEUES);
    assign in_head  = head_reg[in_qid];
    // enqueue works on the free-list head, dequeue on the queue head
    assign in_ptr   = (in_func == sbmq_pkg::FN_ENQ) ? free_head_reg : in_head;

    always_comb
    begin
        op_next         = op_reg;
        if (accept)
        begin
            op_next.func    = in_func;
            op_next.qid     = in_qid;
            op_next.value   = s_tdata[2 +: sbmq_pkg::DATA_WIDTH];
            op_next.slot    = in_ptr[sbmq_pkg::SLOT_W-1:0];
            op_next.ok      = in_q_ok && (in_ptr < sbmq_pkg::NIL_PTR);
            op_next.q_empty = !(in_head < sbmq_pkg::NIL_PTR);
        end
    end

    assign q_tail   = tail_reg[op_reg.qid];
    // an enqueue does not set the new tail's link to null, so the tail compare ends the chain
    assign next_ptr = (op_reg.slot == q_tail || !(link_rd < sbmq_pkg::NIL_PTR))
                    ? sbmq_pkg::NIL_PTR : link_rd;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        free_head_next = free_head_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        link_wr_en     = 1'b0;
        link_wr_addr   = q_tail;
        link_wr_data   = sbmq_pkg::PTR_W'(op_reg.slot);
        data_wr_en     = 1'b0;
        tail_wr_en     = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (op_reg.func == sbmq_pkg::FN_ENQ)
                    begin
                        m_tuser_next = op_reg.ok ? sbmq_pkg::ST_OK : sbmq_pkg::ST_OVERFLOW;
                        if (op_reg.ok)
                        begin
                            free_head_next = link_rd;
                            data_wr_en     = 1'b1;
                            tail_wr_en     = 1'b1;
                            if (op_reg.q_empty)
                            begin
                                head_next[op_reg.qid] = sbmq_pkg::PTR_W'(op_reg.slot);
                            end
                            else
                            begin
                                link_wr_en = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        m_tuser_next = op_reg.ok ? sbmq_pkg::ST_OK : sbmq_pkg::ST_UNDERFLOW;
                        if (op_reg.ok)
                        begin
                            head_next[op_reg.qid] = next_ptr;
                            link_wr_en     = 1'b1;
                            link_wr_addr   = op_reg.slot;
                            link_wr_data   = free_head_reg;
                            free_head_next = sbmq_pkg::PTR_W'(op_reg.slot);
                            m_tdata_next   = 32'(data_rd);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < sbmq_pkg::QUEUES; i++)
            begin
                head_reg[i] <= sbmq_pkg::NIL_PTR;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            m_tvalid_reg  <= m_tvalid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (tail_wr_en)
        begin
            tail_reg[op_reg.qid] <= op_reg.slot;
        end
    end

    sbmq_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (accept),
        .rd_addr (in_ptr[sbmq_pkg::SLOT_W-1:0]),
        .rd_data (link_rd)
    );

    sbmq_data_mem u_data_mem (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (op_reg.slot),
        .wr_data (op_reg.value),
        .rd_en   (accept),
        .rd_addr (in_ptr[sbmq_pkg::SLOT_W-1:0]),
        .rd_data (data_rd)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for shared_buffer_multi_queue_core: enqueue/dequeue items on four queues
// sharing one slot store, checked against a linked-list predictor. Depends on sbmq_pkg and the
// core RTL.
`default_nettype none

module tb_top;

    import sbmq_pkg::*;

    typedef struct {
        status_t           status;
        logic [VAL_W-1:0]  value;
    } reply_t;

    localparam int STALL_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic [1:0]        m_tuser;

    // predictor state: queue chains threaded through a link table, plus a free list
    logic [PTR_W-1:0]       q_head [0:QUEUES-1];
    logic [PTR_W-1:0]       q_tail [0:QUEUES-1];
    logic [PTR_W-1:0]       next_slot [0:SLOTS-1];
    logic [DATA_WIDTH-1:0]  slot_value [0:SLOTS-1];
    logic [PTR_W-1:0]       free_slot;

    reply_t  due_replies [$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic    stall_req = 1'b0;
    int      stall_cnt = 0;

    shared_buffer_multi_queue_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [1:0] queue_id, [33:2] value_in, [39:34] zero
        .s_tuser  (s_tuser),   // [0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] value_out
        .m_tuser  (m_tuser)    // [1:0] status
    );

    always #10 clk = ~clk;

    function automatic reply_t predict_queue_op(func_t f, logic [QID_W-1:0] q,
                                                logic [VAL_W-1:0] v);
        reply_t            r;
        logic [PTR_W-1:0]  s;
        logic [PTR_W-1:0]  nx;
        r.status = ST_OK;
        r.value  = '0;
        if (f == FN_ENQ)
        begin
            if (int'(q) >= QUEUES || free_slot >= SLOTS)
                r.status = ST_OVERFLOW;
            else
            begin
                s = free_slot;
                free_slot = next_slot[s];
                if (q_head[q] >= SLOTS)
                    q_head[q] = s;
                else if (q_tail[q] < SLOTS)
                    next_slot[q_tail[q]] = s;
                slot_value[s] = v[DATA_WIDTH-1:0];
                q_tail[q] = s;
                next_slot[s] = NIL_PTR;
            end
        end
        else
        begin
            if (int'(q) >= QUEUES || q_head[q] >= SLOTS)
                r.status = ST_UNDERFLOW;
            else
            begin
                s = q_head[q];
                nx = next_slot[s];
                q_head[q] = (nx < SLOTS) ? nx : NIL_PTR;
                next_slot[s] = free_slot;
                free_slot = s;
                r.value = VAL_W'(slot_value[s]);
            end
        end
        return r;
    endfunction

    // drive one item, hold it until taken, then record what it should return
    task automatic send_item(input func_t f, input logic [QID_W-1:0] q,
                             input logic [VAL_W-1:0] v, output status_t st);
        reply_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, v, q};
        s_tuser  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_queue_op(f, q, v);
        due_replies.push_back(r);
        st = r.status;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result status=%0d value=%h", $time, m_tuser, m_tdata);
            end
            else
            begin
                want = due_replies.pop_front();
                if (m_tuser !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata !== want.value)
                begin
                    mismatches++;
                    $display("%0t: value_out mismatch expected=%h actual=%h",
                             $time, want.value, m_tdata);
                end
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            m_tready <= 1'b0;
            if (stall_cnt == STALL_CYCLES - 1)
            begin
                stall_cnt <= 0;
                stall_req <= 1'b0;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        status_t st;
        for (int q = 0; q < QUEUES; q++)
            send_item(FN_DEQ, QID_W'(q), $urandom, st);
        send_item(FN_ENQ, 2'd0, 32'h0000_0000, st);
        send_item(FN_ENQ, 2'd0, 32'hffff_ffff, st);
        send_item(FN_ENQ, 2'd1, 32'h8000_0000, st);
        send_item(FN_ENQ, 2'd2, 32'h7fff_ffff, st);
        send_item(FN_ENQ, 2'd3, 32'ha5a5_a5a5, st);
        send_item(FN_ENQ, 2'd3, 32'h5a5a_5a5a, st);
        send_item(FN_DEQ, 2'd3, 32'hffff_ffff, st);
        send_item(FN_DEQ, 2'd0, 32'h0, st);
        send_item(FN_DEQ, 2'd1, 32'h0, st);
        send_item(FN_DEQ, 2'd2, 32'h0, st);
        send_item(FN_DEQ, 2'd2, 32'h0, st);
        send_item(FN_DEQ, 2'd0, 32'h0, st);
        send_item(FN_DEQ, 2'd3, 32'h0, st);
        send_item(FN_DEQ, 2'd0, 32'h0, st);
        // freed slots come back off the free list in LIFO order
        send_item(FN_ENQ, 2'd1, 32'h0000_0001, st);
        send_item(FN_DEQ, 2'd1, 32'h0, st);
    endtask

    // run the store into overflow, then empty every queue into underflow
    task automatic test_fill_and_drain();
        status_t st;
        do
            send_item(FN_ENQ, QID_W'($urandom_range(QUEUES - 1)), pick_value(), st);
        while (st != ST_OVERFLOW);
        send_item(FN_ENQ, QID_W'($urandom_range(QUEUES - 1)), pick_value(), st);
        for (int q = 0; q < QUEUES; q++)
        begin
            do
                send_item(FN_DEQ, QID_W'(q), $urandom, st);
            while (st != ST_UNDERFLOW);
        end
    endtask

    // occupancy swings between near-empty and full in biased stretches
    task automatic test_random_mix(input int n);
        status_t           st;
        int                enq_pct;
        logic [QID_W-1:0]  hot_q;
        logic [QID_W-1:0]  q;
        enq_pct = 50;
        hot_q = '0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 75;
                    1:       enq_pct = 25;
                    default: enq_pct = 50;
                endcase
                hot_q = QID_W'($urandom_range(QUEUES - 1));
            end
            q = ($urandom_range(1)) ? hot_q : QID_W'($urandom_range(QUEUES - 1));
            if ($urandom_range(99) < enq_pct)
                send_item(FN_ENQ, q, pick_value(), st);
            else
                send_item(FN_DEQ, q, $urandom, st);
        end
    endtask

    // long output hold-off while items keep coming, so the input side stalls
    task automatic test_backpressure();
        status_t st;
        stall_req <= 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(func_t'(i % 3 == 2), QID_W'(i % QUEUES), pick_value(), st);
        while (stall_req)
            @(posedge clk);
    endtask

    initial
    begin
        for (int q = 0; q < QUEUES; q++)
        begin
            q_head[q] = NIL_PTR;
            q_tail[q] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            next_slot[i]  = (i + 1 < SLOTS) ? PTR_W'(i + 1) : NIL_PTR;
            slot_value[i] = '0;
        end
        free_slot = '0;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FN_ENQ;
        m_tready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 66;
        test_directed();
        test_fill_and_drain();
        test_random_mix(540);
        test_backpressure();

        send_idle_pct = 66;
        recv_idle_pct = 26;
        test_fill_and_drain();
        test_random_mix(540);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_fill_and_drain();
        test_random_mix(540);

        s_tvalid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
